>>> rtl/core/sha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and helpers of the SHA-256 hash engine.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef logic [31:0] word_t;

    // Eight 32-bit words: working variables a..h or chaining value H0..H7.
    typedef word_t hash_vars_t [8];

    // Control of the message schedule window for one cycle.
    typedef struct packed {
        logic load;  // shift in a message word
        logic step;  // shift in the next expanded schedule word
    } sched_ctrl_t;

    localparam int unsigned ROUNDS    = 64;
    localparam int unsigned WIN_DEPTH = 16;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam word_t      PAD_WORD = {PAD_BYTE, 24'h000000};

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam hash_vars_t INIT_H = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/sha_sched.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha_sched
// Sixteen-word message schedule window, built as a shift line.
// Message words shift in during block load; during the rounds the next
// schedule word is expanded from fixed taps and shifted in.
// ----------------------------------------------------------------------------
module sha_sched
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire sched_ctrl_t ctrl,
    input  wire word_t       load_word,
    output word_t            w_cur
);

    word_t win_reg [WIN_DEPTH];
    word_t expand_next;
    word_t shift_in;

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Entry 0 holds W[t]; W[t+16] follows from W[t+14], W[t+9], W[t+1], W[t].
    always_comb
    begin
        expand_next = small_sigma1(win_reg[14]) + win_reg[9]
                      + small_sigma0(win_reg[1]) + win_reg[0];
        shift_in    = ctrl.load ? load_word : expand_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load || ctrl.step)
        begin
            for (int i = 0; i < WIN_DEPTH - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[WIN_DEPTH - 1] <= shift_in;
        end
    end

    assign w_cur = win_reg[0];

endmodule
`default_nettype wire

>>> rtl/core/sha_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha_round
// One SHA-256 compression round, shared by all 64 rounds of a block.
// ----------------------------------------------------------------------------
module sha_round
    import sha_pkg::*;
(
    input  wire hash_vars_t vars,
    input  wire word_t      k,
    input  wire word_t      w,
    output hash_vars_t      vars_out
);

    word_t t1;
    word_t t2;

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    always_comb
    begin
        t1 = vars[7] + big_sigma1(vars[4]) + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6]))
             + k + w;
        t2 = big_sigma0(vars[0])
             + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));
        vars_out[0] = t1 + t2;
        vars_out[1] = vars[0];
        vars_out[2] = vars[1];
        vars_out[3] = vars[2];
        vars_out[4] = vars[3] + t1;
        vars_out[5] = vars[4];
        vars_out[6] = vars[5];
        vars_out[7] = vars[6];
    end

endmodule
`default_nettype wire

>>> rtl/core/sha256_hash_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_hash_engine
// Streaming SHA-256 over big-endian 32-bit message words.
// ----------------------------------------------------------------------------
// A transaction is accepted on a rising edge with start high and busy low:
// message_word, word_bytes and is_last are taken then. A word that is not the
// last is taken without raising busy, except the sixteenth word of a block,
// which starts a compression: 64 rounds of the single shared round unit, one
// per cycle, then a fold of the result into the chaining value, all while busy
// stays high. The last word triggers padding: the pad, zero and length words
// shift into the schedule window one per cycle, with one or two compressions
// as needed, then the eight digest words come out on consecutive cycles, each
// marked by result_valid for one cycle with word_index 0..7 and last_word on
// index 7. The receiver cannot stall the results. After the digest the engine
// is ready for a new message. Reset loads the initial hash value and clears
// the bit count and word position; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha256_hash_engine
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] message_word,
    input  wire logic [2:0]  word_bytes,
    input  wire logic        is_last,
    output logic             result_valid,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_COMPRESS,
        ST_FINISH,
        ST_OUTPUT
    } state_t;

    typedef enum logic [2:0] {
        PH_PAD,
        PH_ZERO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DONE
    } phase_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    hash_vars_t  chain_reg, chain_next;
    hash_vars_t  work_reg, work_next;
    logic [63:0] bit_count_reg, bit_count_next;
    logic [3:0]  pos_reg, pos_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        finishing_reg, finishing_next;
    logic        result_valid_reg, result_valid_next;
    word_t       digest_word_reg, digest_word_next;
    logic [2:0]  word_index_reg, word_index_next;
    logic        last_word_reg, last_word_next;

    sched_ctrl_t sched_ctrl;
    word_t       load_word;
    word_t       w_cur;
    hash_vars_t  round_out;
    logic [2:0]  nbytes;
    phase_t      after_fill;

    sha_sched u_sched (
        .clk       (clk),
        .ctrl      (sched_ctrl),
        .load_word (load_word),
        .w_cur     (w_cur)
    );

    sha_round u_round (
        .vars     (work_reg),
        .k        (ROUND_K[round_reg]),
        .w        (w_cur),
        .vars_out (round_out)
    );

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        chain_next        = chain_reg;
        work_next         = work_reg;
        bit_count_next    = bit_count_reg;
        pos_next          = pos_reg;
        round_next        = round_reg;
        out_idx_next      = out_idx_reg;
        finishing_next    = finishing_reg;
        result_valid_next = 1'b0;
        digest_word_next  = digest_word_reg;
        word_index_next   = word_index_reg;
        last_word_next    = last_word_reg;
        sched_ctrl        = '0;
        load_word         = '0;
        nbytes            = (word_bytes > 3'd4) ? 3'd4 : word_bytes;
        // After a pad or zero word, either more zeros or the length follows.
        after_fill        = (pos_reg == 4'd13) ? PH_LEN_HI : PH_ZERO;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sched_ctrl.load = 1'b1;
                    pos_next        = pos_reg + 4'd1;
                    if (!is_last)
                    begin
                        load_word      = message_word;
                        bit_count_next = bit_count_reg + 64'd32;
                    end
                    else
                    begin
                        finishing_next = 1'b1;
                        bit_count_next = bit_count_reg + 64'({nbytes, 3'b000});
                        phase_next     = after_fill;
                        case (nbytes)
                            3'd0:    load_word = PAD_WORD;
                            3'd1:    load_word = {message_word[31:24], PAD_BYTE, 16'h0000};
                            3'd2:    load_word = {message_word[31:16], PAD_BYTE, 8'h00};
                            3'd3:    load_word = {message_word[31:8], PAD_BYTE};
                            default:
                            begin
                                load_word  = message_word;
                                phase_next = PH_PAD;
                            end
                        endcase
                    end
                    if (pos_reg == 4'd15)
                    begin
                        state_next = ST_COMPRESS;
                        work_next  = chain_reg;
                        round_next = '0;
                    end
                    else if (is_last)
                    begin
                        state_next = ST_PUSH;
                    end
                end
            end

            ST_PUSH:
            begin
                sched_ctrl.load = 1'b1;
                pos_next        = pos_reg + 4'd1;
                case (phase_reg)
                    PH_PAD:
                    begin
                        load_word  = PAD_WORD;
                        phase_next = after_fill;
                    end
                    PH_ZERO:
                    begin
                        load_word  = '0;
                        phase_next = after_fill;
                    end
                    PH_LEN_HI:
                    begin
                        load_word  = bit_count_reg[63:32];
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        load_word  = bit_count_reg[31:0];
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        sched_ctrl.load = 1'b0;
                        pos_next        = pos_reg;
                    end
                endcase
                if (pos_reg == 4'd15)
                begin
                    state_next = ST_COMPRESS;
                    work_next  = chain_reg;
                    round_next = '0;
                end
            end

            ST_COMPRESS:
            begin
                sched_ctrl.step = 1'b1;
                work_next       = round_out;
                round_next      = round_reg + 6'd1;
                if (round_reg == 6'(ROUNDS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                if (!finishing_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (phase_reg == PH_DONE)
                begin
                    state_next   = ST_OUTPUT;
                    out_idx_next = '0;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end

            ST_OUTPUT:
            begin
                result_valid_next = 1'b1;
                digest_word_next  = chain_reg[out_idx_reg];
                word_index_next   = out_idx_reg;
                last_word_next    = (out_idx_reg == 3'd7);
                out_idx_next      = out_idx_reg + 3'd1;
                if (out_idx_reg == 3'd7)
                begin
                    state_next     = ST_IDLE;
                    chain_next     = INIT_H;
                    bit_count_next = '0;
                    pos_next       = '0;
                    finishing_next = 1'b0;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_PAD;
            chain_reg        <= INIT_H;
            work_reg         <= '{default: '0};
            bit_count_reg    <= '0;
            pos_reg          <= '0;
            round_reg        <= '0;
            out_idx_reg      <= '0;
            finishing_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            digest_word_reg  <= '0;
            word_index_reg   <= '0;
            last_word_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            chain_reg        <= chain_next;
            work_reg         <= work_next;
            bit_count_reg    <= bit_count_next;
            pos_reg          <= pos_next;
            round_reg        <= round_next;
            out_idx_reg      <= out_idx_next;
            finishing_reg    <= finishing_next;
            result_valid_reg <= result_valid_next;
            digest_word_reg  <= digest_word_next;
            word_index_reg   <= word_index_next;
            last_word_reg    <= last_word_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign digest_word  = digest_word_reg;
    assign word_index   = word_index_reg;
    assign last_word    = last_word_reg;

endmodule
`default_nettype wire

>>> verif/sha256_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches the word input and the digest output of the hash engine, keeps its
// own SHA-256 state per accepted transaction and compares every digest word
// with the predicted one.
// ----------------------------------------------------------------------------
module sha256_digest_checker
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [31:0] message_word,
    input  wire logic [2:0]  word_bytes,
    input  wire logic        is_last,
    input  wire logic        result_valid,
    input  wire logic [31:0] digest_word,
    input  wire logic [2:0]  word_index,
    input  wire logic        last_word,
    output int               fail_count,
    output int               outstanding
);

    typedef struct {
        word_t      digest;
        logic [2:0] index;
        logic       tail;
    } digest_exp_t;

    digest_exp_t digest_q [$];

    hash_vars_t  chain_h;
    word_t       sched [WIN_DEPTH];
    logic [63:0] msg_bits;
    logic [3:0]  slot;
    int          errors;

    function automatic word_t ror32(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress_block();
        word_t v [8];
        word_t w, t1, t2, s0, s1, x2, x15;
        for (int i = 0; i < 8; i++)
            v[i] = chain_h[i];
        for (int t = 0; t < ROUNDS; t++)
        begin
            // The window doubles as the rolling message schedule.
            if (t >= 16)
            begin
                x2  = sched[(t - 2) & 15];
                x15 = sched[(t - 15) & 15];
                s1  = ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10);
                s0  = ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3);
                sched[t & 15] = s1 + sched[(t - 7) & 15] + s0 + sched[t & 15];
            end
            w  = sched[t & 15];
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_h[i] = chain_h[i] + v[i];
    endfunction

    function automatic void push_word(input word_t w);
        sched[slot] = w;
        slot = slot + 4'd1;
        if (slot == 4'd0)
            compress_block();
    endfunction

    function automatic void absorb_word(input word_t w, input logic [2:0] nbytes,
                                        input logic tail);
        int unsigned nb;
        word_t       keep;
        digest_exp_t e;
        if (!tail)
        begin
            // Inner words always count as four bytes.
            msg_bits = msg_bits + 64'd32;
            push_word(w);
            return;
        end
        nb = (nbytes > 3'd4) ? 4 : nbytes;
        msg_bits = msg_bits + 64'(nb) * 64'd8;
        if (nb == 4)
        begin
            push_word(w);
            push_word(PAD_WORD);
        end
        else
        begin
            keep = (nb == 0) ? '0 : (32'hffff_ffff << (32 - 8 * nb));
            push_word((w & keep) | (word_t'(PAD_BYTE) << (24 - 8 * nb)));
        end
        // No room left for the length: pad out this block and start another.
        if (slot > 4'd14)
            while (slot != 4'd0)
                push_word('0);
        while (slot < 4'd14)
            push_word('0);
        push_word(msg_bits[63:32]);
        push_word(msg_bits[31:0]);
        for (int k = 0; k < 8; k++)
        begin
            e.digest = chain_h[k];
            e.index  = 3'(k);
            e.tail   = (k == 7);
            digest_q.push_back(e);
        end
        chain_h  = INIT_H;
        msg_bits = '0;
        slot     = '0;
    endfunction

    initial
    begin
        chain_h     = INIT_H;
        msg_bits    = '0;
        slot        = '0;
        errors      = 0;
        for (int i = 0; i < WIN_DEPTH; i++)
            sched[i] = '0;
    end

    always @(posedge clk)
    begin
        digest_exp_t e;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (digest_q.size() == 0)
                begin
                    $display("%0t: unexpected digest word %h (index %0d)",
                             $time, digest_word, word_index);
                    errors++;
                end
                else
                begin
                    e = digest_q.pop_front();
                    if (digest_word !== e.digest)
                    begin
                        $display("%0t: digest_word expected %h actual %h",
                                 $time, e.digest, digest_word);
                        errors++;
                    end
                    if (word_index !== e.index)
                    begin
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, e.index, word_index);
                        errors++;
                    end
                    if (last_word !== e.tail)
                    begin
                        $display("%0t: last_word expected %b actual %b",
                                 $time, e.tail, last_word);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                absorb_word(message_word, word_bytes, is_last);
        end
        fail_count  <= errors;
        outstanding <= digest_q.size();
    end

endmodule

>>> verif/tb_sha256_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_hash_engine
// Feeds the hash engine with directed and random messages under varying
// sender idle rates; the checker beside the engine predicts and compares
// every digest word.
// ----------------------------------------------------------------------------
module tb_sha256_hash_engine;

    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_ITEMS = 80;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] message_word;
    logic [2:0]  word_bytes;
    logic        is_last;
    logic        result_valid;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    int fail_count;
    int outstanding;
    int idle_pct;
    int words_sent;
    int quiet_cycles;

    sha256_hash_engine uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .message_word (message_word),
        .word_bytes   (word_bytes),
        .is_last      (is_last),
        .result_valid (result_valid),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

    sha256_digest_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .message_word (message_word),
        .word_bytes   (word_bytes),
        .is_last      (is_last),
        .result_valid (result_valid),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    // Ends the run when neither a transaction nor a digest word moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_word(input logic [31:0] w, input logic [2:0] nbytes,
                             input logic tail);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        message_word <= w;
        word_bytes   <= nbytes;
        is_last      <= tail;
        // Values read right after the edge are those the engine sampled.
        do
            @(posedge clk);
        while (busy);
        words_sent++;
    endtask

    task automatic send_message(input int unsigned n_words);
        for (int i = 0; i < n_words; i++)
            send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
        send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
    endtask

    initial
    begin
        int phase_idle [4];
        int goal;
        phase_idle   = '{0, 46, 0, 15};
        rst_n        = 1'b0;
        start        = 1'b0;
        message_word = '0;
        word_bytes   = '0;
        is_last      = 1'b0;
        idle_pct     = 0;
        words_sent   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty message, the "abc" vector, each tail byte count with the
        // oversized counts, and a message whose length spills into a second block.
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'h6162_6300, 3'd3, 1'b1);
        send_word(32'hffff_ffff, 3'd1, 1'b1);
        send_word(32'hffff_ffff, 3'd2, 1'b1);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'hffff_ffff, 3'd5, 1'b1);
        send_word(32'hffff_ffff, 3'd6, 1'b1);
        send_word(32'hffff_ffff, 3'd7, 1'b1);
        for (int i = 0; i < 14; i++)
            send_word(32'hffff_ffff, 3'd0, 1'b0);
        send_word(32'ha5a5_5a5a, 3'd2, 1'b1);

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_idle[p];
            goal = words_sent + RANDOM_ITEMS / 4;
            while (words_sent < goal)
            begin
                // Mostly short messages; some span two or three blocks once padded.
                if ($urandom_range(0, 3) == 0)
                    send_message($urandom_range(14, 34));
                else
                    send_message($urandom_range(0, 15));
            end
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
